[rtl/b64e_pkg.sv]
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the character table of the base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] PAD_CHAR = 8'h3d;
    localparam logic [5:0] SEXTET_MASK = 6'h3f;

    localparam logic [1:0] PHASE_START = 2'd0;
    localparam logic [1:0] PHASE_ONE   = 2'd1;
    localparam logic [1:0] PHASE_TWO   = 2'd2;

    localparam logic [1:0] PADS_NONE = 2'd0;
    localparam logic [1:0] PADS_ONE  = 2'd1;
    localparam logic [1:0] PADS_TWO  = 2'd2;

    typedef struct packed {
        logic [23:0] group;
        logic [1:0]  pads;
        logic        fin;
    } job_t;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] v8;
        logic [7:0] ch;
        v8 = {2'b00, v};
        if (v < 6'd26)
            ch = 8'h41 + v8;
        else if (v < 6'd52)
            ch = 8'h61 + v8 - 8'd26;
        else if (v < 6'd62)
            ch = 8'h30 + v8 - 8'd52;
        else if (v == 6'd62)
            ch = 8'h2b;
        else
            ch = 8'h2f;
        return ch;
    endfunction

endpackage

[rtl/b64e_front.sv]
// ----------------------------------------------------------------------------
// b64e_front
// Accepts raw bytes, gathers them into groups of three and pushes one job
// per complete or final group into the queue.
// ----------------------------------------------------------------------------
module b64e_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,    // data_byte[7:0]
    input  logic          s_tlast,    // final_byte
    input  logic          q_full,
    output logic          push,
    output b64e_pkg::job_t push_job
);
    import b64e_pkg::*;

    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic [15:0] pend_reg;
    logic [15:0] pend_next;
    logic        accept;
    logic [1:0]  phase;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign phase    = (phase_reg == PHASE_ONE || phase_reg == PHASE_TWO) ? phase_reg
                                                                         : PHASE_START;

    always_comb
    begin
        phase_next     = phase_reg;
        pend_next      = pend_reg;
        push           = 1'b0;
        push_job.fin   = s_tlast;
        push_job.group = {pend_reg, s_tdata};
        push_job.pads  = PADS_NONE;
        unique case (phase)
            PHASE_ONE:
            begin
                push_job.group = {pend_reg[15:8], s_tdata, 8'h00};
                push_job.pads  = PADS_ONE;
                if (accept)
                begin
                    pend_next  = {pend_reg[15:8], s_tdata};
                    push       = s_tlast;
                    phase_next = s_tlast ? PHASE_START : PHASE_TWO;
                end
            end
            PHASE_TWO:
            begin
                if (accept)
                begin
                    push       = 1'b1;
                    phase_next = PHASE_START;
                end
            end
            default:
            begin
                push_job.group = {s_tdata, 16'h0000};
                push_job.pads  = PADS_TWO;
                if (accept)
                begin
                    pend_next  = {s_tdata, 8'h00};
                    push       = s_tlast;
                    phase_next = s_tlast ? PHASE_START : PHASE_ONE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PHASE_START;
        else
            phase_reg <= phase_next;
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("push into full queue");

    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("group phase out of range");

    a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tlast |=> phase_reg == PHASE_START)
        else $error("phase not cleared after final byte");

endmodule

[rtl/b64e_queue.sv]
// ----------------------------------------------------------------------------
// b64e_queue
// Short job queue between the byte front and the character back.
// ----------------------------------------------------------------------------
module b64e_queue #(
    parameter int DEPTH = b64e_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  b64e_pkg::job_t push_job,
    output logic           full,
    output logic           not_empty,
    input  logic           pop,
    output b64e_pkg::job_t head
);
    import b64e_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count overflow");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

    a_cnt_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count not advanced on push");

endmodule

[rtl/b64e_back.sv]
// ----------------------------------------------------------------------------
// b64e_back
// Expands the job at the queue head into four characters, one per cycle while m_tready is high,
// through an output register.
// ----------------------------------------------------------------------------
module b64e_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    input  b64e_pkg::job_t job,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,   // out_char[7:0]
    output logic           m_tlast,   // run_end
    output logic           m_tuser    // message_end
);
    import b64e_pkg::*;

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] char_reg;
    logic       last_reg;
    logic       msg_end_reg;
    logic       load;
    logic [5:0] sextet;
    logic [7:0] ch;
    logic       is_pad;

    assign load = job_valid && (!valid_reg || m_tready);
    assign pop  = load && (idx_reg == 2'd3);

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    sextet = job.group[23:18] & SEXTET_MASK;
            2'd1:    sextet = job.group[17:12] & SEXTET_MASK;
            2'd2:    sextet = job.group[11:6] & SEXTET_MASK;
            default: sextet = job.group[5:0] & SEXTET_MASK;
        endcase
        is_pad = ({1'b0, idx_reg} >= (3'd4 - {1'b0, job.pads}));
        ch     = is_pad ? PAD_CHAR : b64_char(sextet);
    end

    always_comb
    begin
        idx_next   = load ? idx_reg + 1'b1 : idx_reg;
        valid_next = load ? 1'b1 : (m_tready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg    <= ch;
            last_reg    <= (idx_reg == 2'd3);
            msg_end_reg <= (idx_reg == 2'd3) && job.fin;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = char_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = msg_end_reg;

    a_msg_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("message end without run end");

    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> idx_reg == 2'd0 && m_tvalid && m_tlast)
        else $error("run end out of step with job pop");

    a_pad_tail: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast && !m_tuser |-> m_tdata != PAD_CHAR)
        else $error("pad inside a message");

endmodule

[rtl/base64_stream_encoder.sv]
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder, standard alphabet with '=' padding.
// ----------------------------------------------------------------------------
// Raw bytes enter one per item on the s_ side, s_tlast marking the last byte
// of a message; characters leave one per item on the m_ side, m_tlast on the
// fourth character of each group and m_tuser on the last character of the
// message. A byte is taken whenever the job queue has room; each completed
// or final group becomes four characters that leave the output register at
// one per cycle while m_tready is high, so the sustained input rate is set
// by the single character output. After the byte that closes a group is
// taken, its job is written to the job queue and its first character then
// to the output register, which presents it with m_tvalid.
// ----------------------------------------------------------------------------
module base64_stream_encoder #(
    parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // data_byte[7:0]
    input  logic       s_tlast,    // final_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // out_char[7:0]
    output logic       m_tlast,    // run_end
    output logic       m_tuser     // message_end
);
    import b64e_pkg::*;

    logic q_full;
    logic q_not_empty;
    logic push;
    logic pop;
    job_t push_job;
    job_t head;

    b64e_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (pop),
        .head      (head)
    );

    b64e_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_not_empty),
        .job       (head),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
